FILE: design/assert_macros.svh
// Shared assertion shorthands; clk and rst are the block's clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dpt_pkg.sv
package dpt_pkg;

  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 10;
  localparam int REGEN_W  = 7;
  localparam int DRIVE_W  = 11;
  localparam int ACC_W    = 16;
  localparam int FILTER_SHIFT = 4;
  localparam int FB_W     = ACC_W - FILTER_SHIFT;
  localparam int TOL_W    = SAMPLE_W + 1;
  localparam int LIM_W    = POS_W + 1;
  localparam int NUM_W    = 22;
  localparam int DEN_W    = 12;
  localparam int SUM_W    = NUM_W + 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;

  localparam int SCALE_FULL = 1000;
  localparam int HALF_DRIVE = 500;
  localparam int REGEN_STEP = 10;

  localparam int DEFAULT_RANGE_TOLERANCE = 15;
  localparam int DEFAULT_MISMATCH_LIMIT  = 75;
  localparam int DEFAULT_POT_COUNT       = 2;

  localparam logic [SAMPLE_W-1:0] RST_POT1_MIN = 12'd8;
  localparam logic [SAMPLE_W-1:0] RST_POT1_MAX = 12'd450;
  localparam logic [SAMPLE_W-1:0] RST_POT2_MIN = 12'd355;
  localparam logic [SAMPLE_W-1:0] RST_POT2_MAX = 12'd1800;
  localparam logic [POS_W-1:0]    RST_REGEN_END     = 10'd0;
  localparam logic [POS_W-1:0]    RST_FORWARD_START = 10'd175;
  localparam logic [POS_W-1:0]    RST_HALF_POWER    = 10'd665;
  localparam logic [REGEN_W-1:0]  RST_MAX_REGEN     = 7'd0;

  typedef enum logic [2:0] {
    REG_POT1_MIN      = 3'd0,
    REG_POT1_MAX      = 3'd1,
    REG_POT2_MIN      = 3'd2,
    REG_POT2_MAX      = 3'd3,
    REG_REGEN_END     = 3'd4,
    REG_FORWARD_START = 3'd5,
    REG_HALF_POWER    = 3'd6,
    REG_MAX_REGEN     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    FAULT_NONE     = 3'd0,
    FAULT_POT1_HI  = 3'd1,
    FAULT_POT1_LO  = 3'd2,
    FAULT_POT2_HI  = 3'd3,
    FAULT_POT2_LO  = 3'd4,
    FAULT_MISMATCH = 3'd5
  } fault_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_REGEN,
    MODE_FWD_LOW,
    MODE_FWD_HIGH
  } drive_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POT_START,
    ST_POT_WAIT,
    ST_MIX,
    ST_DRV_PREP,
    ST_DRV_START,
    ST_DRV_WAIT,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pot1_min;
    logic [SAMPLE_W-1:0] pot1_max;
    logic [SAMPLE_W-1:0] pot2_min;
    logic [SAMPLE_W-1:0] pot2_max;
    logic [POS_W-1:0]    regen_end;
    logic [POS_W-1:0]    forward_start;
    logic [POS_W-1:0]    half_power_point;
    logic [REGEN_W-1:0]  max_pedal_regen;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic check;
    logic pot_start;
    logic mix;
    logic drv_prep;
    logic drv_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pot_done;
    logic drv_done;
    logic fault;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic             hi;
    logic             lo;
    logic             rev;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } pot_chk_t;

  // Range check, clamp and build the scaling division for one pot.
  function automatic pot_chk_t check_pot(input logic [SAMPLE_W-1:0] s,
                                         input logic [SAMPLE_W-1:0] mn,
                                         input logic [SAMPLE_W-1:0] mx,
                                         input logic [TOL_W-1:0]    tol);
    pot_chk_t            r;
    logic [SAMPLE_W-1:0] c;
    logic [TOL_W-1:0]    low_bound;
    logic [SAMPLE_W-1:0] off;
    c    = s;
    r.hi = 1'b0;
    r.lo = 1'b0;
    if (s > mx) begin
      r.hi = {1'b0, s} > ({1'b0, mx} + tol);
      c    = mx;
    end
    low_bound = ({1'b0, mn} >= tol) ? ({1'b0, mn} - tol) : '0;
    if (s < mn) begin
      r.lo = {1'b0, s} < low_bound;
      c    = mn;
    end
    r.rev = !(mn < mx);
    off   = r.rev ? (c - mx) : (c - mn);
    r.den = r.rev ? (mn - mx) : (mx - mn);
    r.num = NUM_W'(off) * NUM_W'(SCALE_FULL);
    return r;
  endfunction

endpackage

FILE: design/dpt_in_if.sv
interface dpt_in_if
  import dpt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] pot1_sample;
  logic [SAMPLE_W-1:0] pot2_sample;

  modport source (output valid, output pot1_sample, output pot2_sample, input ready);
  modport sink   (input valid, input pot1_sample, input pot2_sample, output ready);
endinterface

FILE: design/dpt_out_if.sv
interface dpt_out_if
  import dpt_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_command;
  logic [2:0]                fault_code;

  modport source (output valid, output drive_command, output fault_code, input ready);
  modport sink   (input valid, input drive_command, input fault_code, output ready);
endinterface

FILE: design/dual_pot_throttle_conditioner.sv
// Throttle pedal conditioner for one or two potentiometers. Each input transaction
// carries the raw ADC samples; each produces exactly one output transaction with a
// drive command in tenths of a percent (negative is regen) and a fault code. A good
// item runs two passes of a two-bits-per-cycle divider (pot scaling, then the drive
// curve) before the next item can be accepted; a faulting item skips the drive curve.
// A finished result waits in the output register while the next item is accepted.
// Calibration registers sit on the APB port at byte address 4*index and should be
// written while no item is in flight.
`include "assert_macros.svh"

module dual_pot_throttle_conditioner
  import dpt_pkg::*;
#(
  parameter int RANGE_TOLERANCE = DEFAULT_RANGE_TOLERANCE,
  parameter int MISMATCH_LIMIT  = DEFAULT_MISMATCH_LIMIT,
  parameter int POT_COUNT       = DEFAULT_POT_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  dpt_in_if.sink            pot_in,
  dpt_out_if.source         cmd_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  dpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pot_in.valid),
    .status   (status),
    .in_ready (pot_in.ready),
    .cmd      (cmd)
  );

  dpt_datapath #(
    .RANGE_TOLERANCE (RANGE_TOLERANCE),
    .MISMATCH_LIMIT  (MISMATCH_LIMIT),
    .POT_COUNT       (POT_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .pot1_sample   (pot_in.pot1_sample),
    .pot2_sample   (pot_in.pot2_sample),
    .out_ready     (cmd_out.ready),
    .status        (status),
    .out_valid     (cmd_out.valid),
    .drive_command (cmd_out.drive_command),
    .fault_code    (cmd_out.fault_code)
  );

  `ASSERT_NEXT(a_one_in_flight, pot_in.valid && pot_in.ready, !pot_in.ready, "accepted while busy")
  `ASSERT_NEXT(a_finish_shows, cmd.finish, cmd_out.valid, "finished result not presented")
  `ASSERT_SAME(a_fault_zero, cmd_out.valid && (cmd_out.fault_code != FAULT_NONE), cmd_out.drive_command == '0, "fault with nonzero drive")
  `ASSERT_SAME(a_drive_range, cmd_out.valid, (cmd_out.drive_command <= 11'sd1000) && (cmd_out.drive_command >= -11'sd1000), "drive out of range")

endmodule

FILE: design/dpt_regs.sv
module dpt_regs
  import dpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pot1_min         <= RST_POT1_MIN;
      cfg.pot1_max         <= RST_POT1_MAX;
      cfg.pot2_min         <= RST_POT2_MIN;
      cfg.pot2_max         <= RST_POT2_MAX;
      cfg.regen_end        <= RST_REGEN_END;
      cfg.forward_start    <= RST_FORWARD_START;
      cfg.half_power_point <= RST_HALF_POWER;
      cfg.max_pedal_regen  <= RST_MAX_REGEN;
    end else if (wr_en) begin
      unique case (idx)
        REG_POT1_MIN:      cfg.pot1_min         <= pwdata[SAMPLE_W-1:0];
        REG_POT1_MAX:      cfg.pot1_max         <= pwdata[SAMPLE_W-1:0];
        REG_POT2_MIN:      cfg.pot2_min         <= pwdata[SAMPLE_W-1:0];
        REG_POT2_MAX:      cfg.pot2_max         <= pwdata[SAMPLE_W-1:0];
        REG_REGEN_END:     cfg.regen_end        <= pwdata[POS_W-1:0];
        REG_FORWARD_START: cfg.forward_start    <= pwdata[POS_W-1:0];
        REG_HALF_POWER:    cfg.half_power_point <= pwdata[POS_W-1:0];
        REG_MAX_REGEN:     cfg.max_pedal_regen  <= pwdata[REGEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POT1_MIN:      prdata = DATA_W'(cfg.pot1_min);
      REG_POT1_MAX:      prdata = DATA_W'(cfg.pot1_max);
      REG_POT2_MIN:      prdata = DATA_W'(cfg.pot2_min);
      REG_POT2_MAX:      prdata = DATA_W'(cfg.pot2_max);
      REG_REGEN_END:     prdata = DATA_W'(cfg.regen_end);
      REG_FORWARD_START: prdata = DATA_W'(cfg.forward_start);
      REG_HALF_POWER:    prdata = DATA_W'(cfg.half_power_point);
      REG_MAX_REGEN:     prdata = DATA_W'(cfg.max_pedal_regen);
    endcase
  end

endmodule

FILE: design/dpt_div.sv
module dpt_div
  import dpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  // nq holds the remaining dividend bits on top and the quotient bits below
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   part_a;
  logic [DEN_W:0]   part_b;
  logic [DEN_W:0]   diff_a;
  logic [DEN_W:0]   diff_b;
  logic             ge_a;
  logic             ge_b;
  logic [DEN_W-1:0] rem_a;
  logic [DEN_W-1:0] rem_b;

  // two restoring steps per cycle
  always_comb begin
    part_a = {rem, nq[NUM_W-1]};
    ge_a   = part_a >= {1'b0, den_r};
    diff_a = part_a - {1'b0, den_r};
    rem_a  = ge_a ? diff_a[DEN_W-1:0] : part_a[DEN_W-1:0];
    part_b = {rem_a, nq[NUM_W-2]};
    ge_b   = part_b >= {1'b0, den_r};
    diff_b = part_b - {1'b0, den_r};
    rem_b  = ge_b ? diff_b[DEN_W-1:0] : part_b[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq    <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      nq  <= {nq[NUM_W-3:0], ge_a, ge_b};
      rem <= rem_b;
    end
  end

  // a zero divisor gives a zero quotient
  assign quo = (den_r == '0) ? '0 : nq;

endmodule

FILE: design/dpt_datapath.sv
module dpt_datapath
  import dpt_pkg::*;
#(
  parameter int RANGE_TOLERANCE = DEFAULT_RANGE_TOLERANCE,
  parameter int MISMATCH_LIMIT  = DEFAULT_MISMATCH_LIMIT,
  parameter int POT_COUNT       = DEFAULT_POT_COUNT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  cfg_t                      cfg,
  input  logic [SAMPLE_W-1:0]       pot1_sample,
  input  logic [SAMPLE_W-1:0]       pot2_sample,
  input  logic                      out_ready,
  output status_t                   status,
  output logic                      out_valid,
  output logic signed [DRIVE_W-1:0] drive_command,
  output logic [2:0]                fault_code
);

  localparam logic [TOL_W-1:0] TOL = TOL_W'(RANGE_TOLERANCE);
  localparam logic [LIM_W-1:0] LIM = LIM_W'(MISMATCH_LIMIT);

  logic [SAMPLE_W-1:0] s1;
  logic [SAMPLE_W-1:0] s2;
  pot_chk_t            chk1;
  pot_chk_t            chk2;
  fault_t              code;
  logic [ACC_W-1:0]    acc;
  drive_mode_t         mode;
  logic                drv_neg;
  logic [NUM_W-1:0]    drv_num;
  logic [DEN_W-1:0]    drv_den;

  logic                div1_start;
  logic [NUM_W-1:0]    div1_num;
  logic [DEN_W-1:0]    div1_den;
  logic                div1_done;
  logic                div2_done;
  logic [NUM_W-1:0]    q1;
  logic [NUM_W-1:0]    q2;

  // first divider scales pot 1, then serves the drive curve
  assign div1_start = cmd.pot_start || cmd.drv_start;
  assign div1_num   = cmd.drv_start ? drv_num : chk1.num;
  assign div1_den   = cmd.drv_start ? drv_den : chk1.den;

  dpt_div u_div1 (
    .clk   (clk),
    .rst   (rst),
    .start (div1_start),
    .num   (div1_num),
    .den   (div1_den),
    .done  (div1_done),
    .quo   (q1)
  );

  dpt_div u_div2 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.pot_start),
    .num   (chk2.num),
    .den   (chk2.den),
    .done  (div2_done),
    .quo   (q2)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s1 <= pot1_sample;
      s2 <= pot2_sample;
    end
    if (cmd.check) begin
      chk1 <= check_pot(s1, cfg.pot1_min, cfg.pot1_max, TOL);
      chk2 <= check_pot(s2, cfg.pot2_min, cfg.pot2_max, TOL);
    end
  end

  // combine the scaled pots, pick the fault code, step the filter
  logic [POS_W-1:0]   v1;
  logic [POS_W-1:0]   v2;
  logic [LIM_W-1:0]   pair_sum;
  logic [POS_W-1:0]   val;
  logic               mismatch;
  fault_t             code1;
  fault_t             code2;
  fault_t             code_next;
  logic [ACC_W-1:0]   acc_next;

  always_comb begin
    v1 = chk1.rev ? (POS_W'(SCALE_FULL) - q1[POS_W-1:0]) : q1[POS_W-1:0];
    v2 = chk2.rev ? (POS_W'(SCALE_FULL) - q2[POS_W-1:0]) : q2[POS_W-1:0];
    pair_sum = {1'b0, v1} + {1'b0, v2};
    mismatch = ({1'b0, v1} > ({1'b0, v2} + LIM)) || ({1'b0, v2} > ({1'b0, v1} + LIM));
    code1 = chk1.lo ? FAULT_POT1_LO : (chk1.hi ? FAULT_POT1_HI : FAULT_NONE);
    code2 = chk2.lo ? FAULT_POT2_LO : (chk2.hi ? FAULT_POT2_HI : FAULT_NONE);
    if (code1 != FAULT_NONE) begin
      code_next = code1;
      val       = v1;
    end else if (POT_COUNT > 1) begin
      code_next = mismatch ? FAULT_MISMATCH : code2;
      val       = pair_sum[LIM_W-1:1];
    end else begin
      code_next = FAULT_NONE;
      val       = v1;
    end
    acc_next = acc + ACC_W'(val) - ACC_W'(acc[ACC_W-1:FILTER_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.mix && (code_next == FAULT_NONE)) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      code <= code_next;
    end
  end

  // set up the drive curve division from the filtered pedal position
  logic [FB_W-1:0]    fb;
  logic               in_regen;
  logic               in_fwd;
  drive_mode_t        mode_next;
  logic [DEN_W-1:0]   mul_a;
  logic [FB_W-1:0]    mul_b;
  logic [DEN_W-1:0]   den_next;
  logic               neg_next;
  logic [DEN_W-1:0]   regen_scale;

  always_comb begin
    fb          = acc[ACC_W-1:FILTER_SHIFT];
    in_regen    = (cfg.regen_end != '0) && (fb <= FB_W'(cfg.regen_end));
    in_fwd      = fb >= FB_W'(cfg.forward_start);
    regen_scale = (DEN_W'(cfg.max_pedal_regen) << 3) + (DEN_W'(cfg.max_pedal_regen) << 1);
    neg_next    = 1'b0;
    if (in_fwd) begin
      mode_next = (fb <= FB_W'(cfg.half_power_point)) ? MODE_FWD_LOW : MODE_FWD_HIGH;
    end else if (in_regen) begin
      mode_next = MODE_REGEN;
    end else begin
      mode_next = MODE_NONE;
    end
    unique case (mode_next)
      MODE_REGEN: begin
        mul_a    = regen_scale;
        mul_b    = FB_W'(cfg.regen_end) - fb;
        den_next = DEN_W'(cfg.regen_end);
      end
      MODE_FWD_LOW: begin
        mul_a    = DEN_W'(HALF_DRIVE);
        mul_b    = fb - FB_W'(cfg.forward_start);
        den_next = DEN_W'(cfg.half_power_point) - DEN_W'(cfg.forward_start);
      end
      MODE_FWD_HIGH: begin
        mul_a = DEN_W'(HALF_DRIVE);
        mul_b = fb - FB_W'(cfg.half_power_point);
        // past full scale the segment runs backward
        if (DEN_W'(cfg.half_power_point) > DEN_W'(SCALE_FULL)) begin
          den_next = DEN_W'(cfg.half_power_point) - DEN_W'(SCALE_FULL);
          neg_next = 1'b1;
        end else begin
          den_next = DEN_W'(SCALE_FULL) - DEN_W'(cfg.half_power_point);
        end
      end
      MODE_NONE: begin
        mul_a    = '0;
        mul_b    = '0;
        den_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.drv_prep) begin
      mode    <= mode_next;
      drv_neg <= neg_next;
      drv_num <= NUM_W'(mul_a) * NUM_W'(mul_b);
      drv_den <= den_next;
    end
  end

  // apply the segment offset and saturate, or give zero on a fault
  logic signed [SUM_W-1:0] qs;
  logic signed [SUM_W-1:0] drive_raw;
  logic signed [SUM_W-1:0] drive_sat;

  always_comb begin
    qs = $signed({2'b00, q1});
    unique case (mode)
      MODE_REGEN:    drive_raw = -qs;
      MODE_FWD_LOW:  drive_raw = qs;
      MODE_FWD_HIGH: drive_raw = drv_neg ? (SUM_W'(HALF_DRIVE) - qs)
                                         : (SUM_W'(HALF_DRIVE) + qs);
      MODE_NONE:     drive_raw = '0;
    endcase
    if (code != FAULT_NONE) begin
      drive_sat = '0;
    end else if (drive_raw > SUM_W'(SCALE_FULL)) begin
      drive_sat = SUM_W'(SCALE_FULL);
    end else if (drive_raw < -SUM_W'(SCALE_FULL)) begin
      drive_sat = -SUM_W'(SCALE_FULL);
    end else begin
      drive_sat = drive_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      drive_command <= drive_sat[DRIVE_W-1:0];
      fault_code    <= code;
    end
  end

  assign status.pot_done = div1_done && div2_done;
  assign status.drv_done = div1_done;
  assign status.fault    = (code != FAULT_NONE);
  assign status.out_free = !out_valid || out_ready;

endmodule

FILE: design/dpt_ctrl.sv
module dpt_ctrl
  import dpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_CHECK;
      ST_CHECK:     state_next = ST_POT_START;
      ST_POT_START: state_next = ST_POT_WAIT;
      ST_POT_WAIT:  if (status.pot_done) state_next = ST_MIX;
      ST_MIX:       state_next = ST_DRV_PREP;
      // a fault skips the drive curve
      ST_DRV_PREP:  state_next = status.fault ? ST_FINISH : ST_DRV_START;
      ST_DRV_START: state_next = ST_DRV_WAIT;
      ST_DRV_WAIT:  if (status.drv_done) state_next = ST_FINISH;
      ST_FINISH:    if (status.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK:     cmd.check     = 1'b1;
      ST_POT_START: cmd.pot_start = 1'b1;
      ST_MIX:       cmd.mix       = 1'b1;
      ST_DRV_PREP:  cmd.drv_prep  = 1'b1;
      ST_DRV_START: cmd.drv_start = 1'b1;
      ST_FINISH:    cmd.finish    = status.out_free;
      default: begin
      end
    endcase
  end

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dpt_pkg::*;

  localparam int RANGE_TOL    = DEFAULT_RANGE_TOLERANCE;
  localparam int MISMATCH_LIM = DEFAULT_MISMATCH_LIMIT;
  localparam int POTS         = DEFAULT_POT_COUNT;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 81;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    fault_t                    fault;
  } cmd_result_t;

  typedef struct packed {
    logic                      is_cfg;
    reg_idx_t                  idx;
    logic [SAMPLE_W-1:0]       value;
    logic [SAMPLE_W-1:0]       p1;
    logic [SAMPLE_W-1:0]       p2;
    logic                      fixed;
    logic signed [DRIVE_W-1:0] drive;
    fault_t                    fault;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dpt_in_if  pot_in ();
  dpt_out_if cmd_out ();

  dual_pot_throttle_conditioner #(
    .RANGE_TOLERANCE (RANGE_TOL),
    .MISMATCH_LIMIT  (MISMATCH_LIM),
    .POT_COUNT       (POTS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .pot_in  (pot_in),
    .cmd_out (cmd_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t              cal;
  logic [ACC_W-1:0]  filter_acc;
  cmd_result_t       pending_cmds [$];
  plan_row_t         directed [$];
  int                mismatches = 0;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                quiet = 0;
  int                pedal = 0;

  always #5 clk = ~clk;

  function automatic int div0(input int n, input int d);
    return (d == 0) ? 0 : n / d;
  endfunction

  // Range check, clamp and scale one pot to 0..1000.
  function automatic int scale_pot(input int s, input int mn, input int mx,
                                   input fault_t hi_code, input fault_t lo_code,
                                   inout fault_t code);
    int c;
    int low_bound;
    c = s;
    if (s > mx) begin
      if (s > mx + RANGE_TOL) code = hi_code;
      c = mx;
    end
    low_bound = (mn >= RANGE_TOL) ? mn - RANGE_TOL : 0;
    if (s < mn) begin
      if (s < low_bound) code = lo_code;
      c = mn;
    end
    if (mn < mx) return div0((c - mn) * SCALE_FULL, mx - mn);
    return SCALE_FULL - div0((c - mx) * SCALE_FULL, mn - mx);
  endfunction

  function automatic cmd_result_t predict_command(input logic [SAMPLE_W-1:0] s1,
                                                  input logic [SAMPLE_W-1:0] s2);
    cmd_result_t r;
    fault_t      code;
    int          v1, v2, val, fb, drive;
    int          re, fs, hp, mr;
    code  = FAULT_NONE;
    drive = 0;
    v1 = scale_pot(s1, cal.pot1_min, cal.pot1_max, FAULT_POT1_HI, FAULT_POT1_LO, code);
    val = v1;
    if (code == FAULT_NONE && POTS > 1) begin
      v2 = scale_pot(s2, cal.pot2_min, cal.pot2_max, FAULT_POT2_HI, FAULT_POT2_LO, code);
      if (v1 - MISMATCH_LIM > v2 || v2 - MISMATCH_LIM > v1) code = FAULT_MISMATCH;
      val = (v1 + v2) / 2;
    end
    // A faulting item leaves the filter untouched.
    if (code == FAULT_NONE) begin
      filter_acc = filter_acc + ACC_W'(val) - (filter_acc >> FILTER_SHIFT);
      fb = filter_acc[ACC_W-1:FILTER_SHIFT];
      re = cal.regen_end;
      fs = cal.forward_start;
      hp = cal.half_power_point;
      mr = cal.max_pedal_regen;
      if (re != 0 && fb <= re) drive = div0(-REGEN_STEP * mr * (re - fb), re);
      if (fb >= fs) begin
        if (fb <= hp) drive = div0(HALF_DRIVE * (fb - fs), hp - fs);
        else drive = HALF_DRIVE + div0(HALF_DRIVE * (fb - hp), SCALE_FULL - hp);
      end
      if (drive > SCALE_FULL) drive = SCALE_FULL;
      if (drive < -SCALE_FULL) drive = -SCALE_FULL;
    end
    r.drive = DRIVE_W'(drive);
    r.fault = code;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input reg_idx_t idx, input int value);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = SAMPLE_W'(value);
    r.fault  = FAULT_NONE;
    return r;
  endfunction

  function automatic plan_row_t item_row(input int p1, input int p2);
    plan_row_t r;
    r       = '0;
    r.p1    = SAMPLE_W'(p1);
    r.p2    = SAMPLE_W'(p2);
    r.fault = FAULT_NONE;
    return r;
  endfunction

  function automatic plan_row_t fixed_row(input int p1, input int p2, input int drive,
                                          input fault_t fault);
    plan_row_t r;
    r       = item_row(p1, p2);
    r.fixed = 1'b1;
    r.drive = DRIVE_W'(drive);
    r.fault = fault;
    return r;
  endfunction

  function automatic int clip_sample(input int v);
    return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
  endfunction

  // Sample a pot would give at the current pedal position, with some wiper noise.
  function automatic int pedal_sample(input int mn, input int mx);
    int jitter;
    jitter = int'($urandom_range(30)) - 15;
    return clip_sample(mn + pedal * (mx - mn) / SCALE_FULL + jitter);
  endfunction

  function automatic int edge_sample(input int mn, input int mx);
    case ($urandom_range(5))
      0: return clip_sample(mn - RANGE_TOL);
      1: return clip_sample(mn - RANGE_TOL - 1);
      2: return clip_sample(mx + RANGE_TOL);
      3: return clip_sample(mx + RANGE_TOL + 1);
      4: return 0;
      default: return SAMPLE_MAX;
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input int value);
    psel   <= 1'b1;
    paddr  <= ADDR_W'(4 * int'(idx));
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_POT1_MIN:      cal.pot1_min = SAMPLE_W'(value);
      REG_POT1_MAX:      cal.pot1_max = SAMPLE_W'(value);
      REG_POT2_MIN:      cal.pot2_min = SAMPLE_W'(value);
      REG_POT2_MAX:      cal.pot2_max = SAMPLE_W'(value);
      REG_REGEN_END:     cal.regen_end = POS_W'(value);
      REG_FORWARD_START: cal.forward_start = POS_W'(value);
      REG_HALF_POWER:    cal.half_power_point = POS_W'(value);
      REG_MAX_REGEN:     cal.max_pedal_regen = REGEN_W'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_cal(input int kind);
    int lo1, hi1, lo2, hi2, re, fs, hp, mr;
    case (kind)
      0: begin
        lo1 = $urandom_range(1500);
        hi1 = lo1 + $urandom_range(2500, 200);
        lo2 = $urandom_range(1500);
        hi2 = lo2 + $urandom_range(2500, 200);
        re  = $urandom_range(1) ? 0 : $urandom_range(400, 1);
        fs  = $urandom_range(500);
        hp  = $urandom_range(1000, fs);
        mr  = $urandom_range(100);
      end
      1: begin
        lo1 = 0; hi1 = SAMPLE_MAX; lo2 = 0; hi2 = SAMPLE_MAX;
        re = SCALE_FULL; fs = SCALE_FULL; hp = SCALE_FULL; mr = 100;
      end
      2: begin
        lo1 = 0; hi1 = SAMPLE_MAX; lo2 = 0; hi2 = SAMPLE_MAX;
        re = 0; fs = 0; hp = 0; mr = 0;
      end
      default: begin
        lo1 = $urandom_range(SAMPLE_MAX);
        hi1 = $urandom_range(SAMPLE_MAX);
        lo2 = $urandom_range(SAMPLE_MAX);
        hi2 = $urandom_range(SAMPLE_MAX);
        re  = $urandom_range(1000);
        fs  = $urandom_range(1000);
        hp  = $urandom_range(1000);
        mr  = $urandom_range(100);
      end
    endcase
    write_reg(REG_POT1_MIN, lo1);
    write_reg(REG_POT1_MAX, hi1);
    write_reg(REG_POT2_MIN, lo2);
    write_reg(REG_POT2_MAX, hi2);
    write_reg(REG_REGEN_END, re);
    write_reg(REG_FORWARD_START, fs);
    write_reg(REG_HALF_POWER, hp);
    write_reg(REG_MAX_REGEN, mr);
  endtask

  task automatic send_item(input int p1, input int p2, input logic fixed,
                           input logic signed [DRIVE_W-1:0] drive, input fault_t fault);
    cmd_result_t want;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      pot_in.valid <= 1'b0;
      @(posedge clk);
    end
    pot_in.valid       <= 1'b1;
    pot_in.pot1_sample <= SAMPLE_W'(p1);
    pot_in.pot2_sample <= SAMPLE_W'(p2);
    @(posedge clk);
    while (!pot_in.ready) @(posedge clk);
    want = predict_command(SAMPLE_W'(p1), SAMPLE_W'(p2));
    if (fixed) begin
      want.drive = drive;
      want.fault = fault;
    end
    pending_cmds.push_back(want);
  endtask

  // Drop valid and hold until every pending command has come out.
  task automatic settle();
    pot_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cmd_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cmd_result_t want;
    if (!rst && cmd_out.valid && cmd_out.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command: expected none, actual drive %0d fault %0d",
                 $time, $signed(cmd_out.drive_command), cmd_out.fault_code);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        if (cmd_out.drive_command !== want.drive) begin
          $display("%0t: drive_command expected %0d actual %0d", $time,
                   $signed(want.drive), $signed(cmd_out.drive_command));
          mismatches++;
        end
        if (cmd_out.fault_code !== want.fault) begin
          $display("%0t: fault_code expected %0d actual %0d", $time,
                   want.fault, cmd_out.fault_code);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pot_in.valid && pot_in.ready) || (cmd_out.valid && cmd_out.ready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int p1, p2, pick;
    pot_in.valid       = 1'b0;
    pot_in.pot1_sample = '0;
    pot_in.pot2_sample = '0;
    cmd_out.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = '0;
    pwdata  = '0;
    cal.pot1_min         = RST_POT1_MIN;
    cal.pot1_max         = RST_POT1_MAX;
    cal.pot2_min         = RST_POT2_MIN;
    cal.pot2_max         = RST_POT2_MAX;
    cal.regen_end        = RST_REGEN_END;
    cal.forward_start    = RST_FORWARD_START;
    cal.half_power_point = RST_HALF_POWER;
    cal.max_pedal_regen  = RST_MAX_REGEN;
    filter_acc = '0;

    // Reset calibration: first item settles at zero drive.
    directed.push_back(fixed_row(8, 355, 0, FAULT_NONE));
    directed.push_back(fixed_row(4095, 0, 0, FAULT_POT1_HI));
    directed.push_back(fixed_row(466, 1077, 0, FAULT_POT1_HI));
    // Pot 1 min is below the tolerance, so zero is not a low fault there.
    directed.push_back(fixed_row(0, 0, 0, FAULT_POT2_LO));
    directed.push_back(fixed_row(450, 1816, 0, FAULT_POT2_HI));
    directed.push_back(fixed_row(450, 355, 0, FAULT_MISMATCH));
    // Pot 2 low fault is overridden by the mismatch.
    directed.push_back(fixed_row(450, 0, 0, FAULT_MISMATCH));
    directed.push_back(fixed_row(0, 4095, 0, FAULT_MISMATCH));
    directed.push_back(item_row(465, 1815));
    directed.push_back(item_row(229, 1077));
    directed.push_back(item_row(0, 340));
    // Reversed pot 1, pot 2 with min equal to max, regen overlapping an empty
    // low forward segment.
    directed.push_back(cfg_row(REG_POT1_MIN, 1010));
    directed.push_back(cfg_row(REG_POT1_MAX, 1000));
    directed.push_back(cfg_row(REG_POT2_MIN, 2000));
    directed.push_back(cfg_row(REG_POT2_MAX, 2000));
    directed.push_back(cfg_row(REG_REGEN_END, 600));
    directed.push_back(cfg_row(REG_FORWARD_START, 300));
    directed.push_back(cfg_row(REG_HALF_POWER, 300));
    directed.push_back(cfg_row(REG_MAX_REGEN, 100));
    directed.push_back(item_row(1012, 2000));
    directed.push_back(fixed_row(1005, 2015, 0, FAULT_MISMATCH));
    directed.push_back(fixed_row(1016, 2000, 0, FAULT_POT1_HI));
    directed.push_back(fixed_row(994, 2000, 0, FAULT_POT1_LO));
    directed.push_back(fixed_row(1012, 1984, 0, FAULT_POT2_LO));
    directed.push_back(fixed_row(1012, 2016, 0, FAULT_POT2_HI));
    directed.push_back(item_row(1015, 1985));
    directed.push_back(item_row(1013, 2000));
    directed.push_back(item_row(1011, 2010));
    // Full-span pots, regen across the whole travel, forward only at the top.
    directed.push_back(cfg_row(REG_POT1_MIN, 0));
    directed.push_back(cfg_row(REG_POT1_MAX, 4095));
    directed.push_back(cfg_row(REG_POT2_MIN, 0));
    directed.push_back(cfg_row(REG_POT2_MAX, 4095));
    directed.push_back(cfg_row(REG_REGEN_END, 1000));
    directed.push_back(cfg_row(REG_FORWARD_START, 1000));
    directed.push_back(cfg_row(REG_HALF_POWER, 1000));
    directed.push_back(item_row(0, 0));
    directed.push_back(item_row(4095, 4095));
    directed.push_back(item_row(2048, 2047));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        send_item(directed[i].p1, directed[i].p2, directed[i].fixed,
                  directed[i].drive, directed[i].fault);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      program_cal((ph == 1) ? 1 : (ph == 3) ? 2 : (ph == 4 || ph == 7) ? 3 : 0);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      pedal = $urandom_range(SCALE_FULL);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        // Walk the pedal so the filter has time to follow; jump now and then.
        if (pick < 5) pedal = $urandom_range(SCALE_FULL);
        else pedal = pedal + int'($urandom_range(100)) - 50;
        if (pedal < 0) pedal = 0;
        if (pedal > SCALE_FULL) pedal = SCALE_FULL;
        p1 = pedal_sample(cal.pot1_min, cal.pot1_max);
        p2 = pedal_sample(cal.pot2_min, cal.pot2_max);
        if (pick >= 90) begin
          p1 = $urandom_range(SAMPLE_MAX);
          p2 = $urandom_range(SAMPLE_MAX);
        end else if (pick >= 80) begin
          if ($urandom_range(1)) p1 = edge_sample(cal.pot1_min, cal.pot1_max);
          else p2 = edge_sample(cal.pot2_min, cal.pot2_max);
        end
        send_item(p1, p2, 1'b0, '0, FAULT_NONE);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
